// File: rtl/core/first_fit_chunk_allocator_assert.svh
// Assertion macros used by the checker file.
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define FFCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define FFCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ffca_pkg.sv
package ffca_pkg;

    localparam int MAX_CHUNKS = 64;
    localparam int WORD_BYTES = 8;
    localparam int SIZE_BITS  = 24;
    localparam int GSZ_W      = SIZE_BITS + 1;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int HANDLE_W   = 6;
    localparam int STATUS_W   = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_FULL = 2'd2,
        ST_BADH = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        RES_FREE,
        RES_REUSE,
        RES_APPEND,
        RES_ZERO,
        RES_FULL,
        RES_BADH
    } t_res_kind;

    typedef struct packed {
        logic      load;
        logic      rd;
        logic      rd_handle;
        logic      res;
        t_res_kind res_kind;
        logic      emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic zero;
        logic bad_handle;
        logic more;
        logic hit;
        logic full;
    } t_dp_stat;

endpackage

// File: rtl/core/ffca_if.sv
interface ffca_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic [ffca_pkg::SIZE_BITS-1:0]       req_size;
    logic [ffca_pkg::HANDLE_W-1:0]        handle;

    modport source (output valid, command, req_size, handle, input ready);
    modport sink (input valid, command, req_size, handle, output ready);
endinterface

interface ffca_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [ffca_pkg::STATUS_W-1:0]        status;
    logic [ffca_pkg::HANDLE_W-1:0]        granted_handle;
    logic [ffca_pkg::GSZ_W-1:0]           granted_size;
    logic                                 reused;

    modport source (output valid, status, granted_handle, granted_size, reused, input ready);
    modport sink (input valid, status, granted_handle, granted_size, reused, output ready);
endinterface

// File: rtl/core/ffca_ctrl.sv
module ffca_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ffca_pkg::t_dp_cmd  o_cmd,
    input  ffca_pkg::t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FREE_WB,
        S_SCAN,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   r_out_vld, n_out_vld;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_pend    = r_pend;
        n_out_vld = r_out_vld && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_pend = 1'b0;
                if (i_stat.is_free) begin
                    if (i_stat.bad_handle) begin
                        o_cmd.res      = 1'b1;
                        o_cmd.res_kind = ffca_pkg::RES_BADH;
                        n_state        = S_OUT;
                    end else begin
                        o_cmd.rd        = 1'b1;
                        o_cmd.rd_handle = 1'b1;
                        n_state         = S_FREE_WB;
                    end
                end else if (i_stat.zero) begin
                    o_cmd.res      = 1'b1;
                    o_cmd.res_kind = ffca_pkg::RES_ZERO;
                    n_state        = S_OUT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_FREE_WB: begin
                o_cmd.res      = 1'b1;
                o_cmd.res_kind = ffca_pkg::RES_FREE;
                n_state        = S_OUT;
            end
            S_SCAN: begin
                if (r_pend && i_stat.hit) begin
                    o_cmd.res      = 1'b1;
                    o_cmd.res_kind = ffca_pkg::RES_REUSE;
                    n_pend         = 1'b0;
                    n_state        = S_OUT;
                end else if (i_stat.more) begin
                    o_cmd.rd = 1'b1;
                    n_pend   = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    o_cmd.res      = 1'b1;
                    o_cmd.res_kind = i_stat.full ? ffca_pkg::RES_FULL : ffca_pkg::RES_APPEND;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// File: rtl/core/ffca_dp.sv
module ffca_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ffca_pkg::t_dp_cmd              i_cmd,
    output ffca_pkg::t_dp_stat             o_stat,
    input  logic                           i_command,
    input  logic [ffca_pkg::SIZE_BITS-1:0] i_req_size,
    input  logic [ffca_pkg::HANDLE_W-1:0]  i_handle,
    output logic [ffca_pkg::STATUS_W-1:0]  o_status,
    output logic [ffca_pkg::HANDLE_W-1:0]  o_granted_handle,
    output logic [ffca_pkg::GSZ_W-1:0]     o_granted_size,
    output logic                           o_reused
);

    // Entry layout: {size, free}.
    logic [ffca_pkg::GSZ_W:0]          r_chunk_mem [ffca_pkg::MAX_CHUNKS];

    logic                              r_is_free;
    logic                              r_zero;
    logic [ffca_pkg::GSZ_W-1:0]        r_need;
    logic [ffca_pkg::HANDLE_W-1:0]     r_handle;
    logic [ffca_pkg::CNT_W-1:0]        r_idx;
    logic [ffca_pkg::CNT_W-1:0]        r_count;
    logic [ffca_pkg::IDX_W-1:0]        r_rd_idx;
    logic [ffca_pkg::GSZ_W-1:0]        r_rd_size;
    logic                              r_rd_free;

    logic [ffca_pkg::STATUS_W-1:0]     r_st_status, n_st_status;
    logic [ffca_pkg::HANDLE_W-1:0]     r_st_handle, n_st_handle;
    logic [ffca_pkg::GSZ_W-1:0]        r_st_size, n_st_size;
    logic                              r_st_reused, n_st_reused;

    logic [ffca_pkg::STATUS_W-1:0]     r_o_status;
    logic [ffca_pkg::HANDLE_W-1:0]     r_o_handle;
    logic [ffca_pkg::GSZ_W-1:0]        r_o_size;
    logic                              r_o_reused;

    logic [ffca_pkg::GSZ_W-1:0]        rnd_sum;
    logic [ffca_pkg::GSZ_W-1:0]        rnd_need;
    logic [ffca_pkg::IDX_W-1:0]        rd_addr;
    logic                              wr_en;
    logic [ffca_pkg::IDX_W-1:0]        wr_addr;
    logic [ffca_pkg::GSZ_W:0]          wr_data;

    // Round up to a whole word; word size is a power of two.
    assign rnd_sum  = ffca_pkg::GSZ_W'(i_req_size) + ffca_pkg::GSZ_W'(ffca_pkg::WORD_BYTES - 1);
    assign rnd_need = rnd_sum & ~ffca_pkg::GSZ_W'(ffca_pkg::WORD_BYTES - 1);

    assign rd_addr = i_cmd.rd_handle ? ffca_pkg::IDX_W'(r_handle)
                                     : r_idx[ffca_pkg::IDX_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rd_idx;
        wr_data = {r_rd_size, 1'b0};
        if (i_cmd.res) begin
            case (i_cmd.res_kind)
                ffca_pkg::RES_FREE: begin
                    wr_en   = 1'b1;
                    wr_data = {r_rd_size, 1'b1};
                end
                ffca_pkg::RES_REUSE: begin
                    wr_en = 1'b1;
                end
                ffca_pkg::RES_APPEND: begin
                    wr_en   = 1'b1;
                    wr_addr = r_count[ffca_pkg::IDX_W-1:0];
                    wr_data = {r_need, 1'b0};
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_st_status = ffca_pkg::ST_OK;
        n_st_handle = '0;
        n_st_size   = '0;
        n_st_reused = 1'b0;
        case (i_cmd.res_kind)
            ffca_pkg::RES_FREE: begin
                n_st_handle = ffca_pkg::HANDLE_W'(r_rd_idx);
                n_st_size   = r_rd_size;
            end
            ffca_pkg::RES_REUSE: begin
                n_st_handle = ffca_pkg::HANDLE_W'(r_rd_idx);
                n_st_size   = r_rd_size;
                n_st_reused = 1'b1;
            end
            ffca_pkg::RES_APPEND: begin
                n_st_handle = ffca_pkg::HANDLE_W'(r_count);
                n_st_size   = r_need;
            end
            ffca_pkg::RES_ZERO: begin
                n_st_status = ffca_pkg::ST_ZERO;
            end
            ffca_pkg::RES_FULL: begin
                n_st_status = ffca_pkg::ST_FULL;
            end
            default: begin
                n_st_status = ffca_pkg::ST_BADH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_chunk_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            {r_rd_size, r_rd_free} <= r_chunk_mem[rd_addr];
            r_rd_idx               <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.res && i_cmd.res_kind == ffca_pkg::RES_APPEND) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_free <= i_command;
            r_zero    <= (i_req_size == '0);
            r_need    <= rnd_need;
            r_handle  <= i_handle;
            r_idx     <= '0;
        end else if (i_cmd.rd && !i_cmd.rd_handle) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.res) begin
            r_st_status <= n_st_status;
            r_st_handle <= n_st_handle;
            r_st_size   <= n_st_size;
            r_st_reused <= n_st_reused;
        end
        if (i_cmd.emit) begin
            r_o_status <= r_st_status;
            r_o_handle <= r_st_handle;
            r_o_size   <= r_st_size;
            r_o_reused <= r_st_reused;
        end
    end

    assign o_stat.is_free    = r_is_free;
    assign o_stat.zero       = r_zero;
    assign o_stat.bad_handle = ({{ffca_pkg::CNT_W{1'b0}}, r_handle}
                                >= {{ffca_pkg::HANDLE_W{1'b0}}, r_count});
    assign o_stat.more       = (r_idx < r_count);
    assign o_stat.hit        = r_rd_free && (r_rd_size >= r_need);
    assign o_stat.full       = (r_count == ffca_pkg::CNT_W'(ffca_pkg::MAX_CHUNKS));

    assign o_status         = r_o_status;
    assign o_granted_handle = r_o_handle;
    assign o_granted_size   = r_o_size;
    assign o_reused         = r_o_reused;

endmodule

// File: rtl/core/first_fit_chunk_allocator.sv
// First-fit chunk allocator. One request word is handled at a time; the
// request port is ready again once the previous result sits in the output
// register, even if that result has not yet been taken. A new result that
// finds the output register still full waits until the held word is taken.
// The chunk table is a single-port memory read one entry per cycle. A free
// reads the handle's entry and writes it back marked free; a free with a bad
// handle and a zero-size allocate are answered without a read. An allocate
// reads the chunks in order and reuses the first free one that is large enough,
// else it appends a chunk, or reports the table full when all 64 entries exist
// and none fits. The table is not cleared after reset; only entries that were
// appended since reset are ever read.
module first_fit_chunk_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffca_req_if.sink   i_req,
    ffca_rsp_if.source o_rsp
);

    ffca_pkg::t_dp_cmd  dp_cmd;
    ffca_pkg::t_dp_stat dp_stat;
    logic               in_ready;
    logic               out_valid;

    ffca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    ffca_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_command        (i_req.command),
        .i_req_size       (i_req.req_size),
        .i_handle         (i_req.handle),
        .o_status         (o_rsp.status),
        .o_granted_handle (o_rsp.granted_handle),
        .o_granted_size   (o_rsp.granted_size),
        .o_reused         (o_rsp.reused)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

endmodule

// File: rtl/core/ffca_checker.sv
`include "first_fit_chunk_allocator_assert.svh"

module ffca_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ffca_pkg::STATUS_W-1:0] i_status,
    input logic [ffca_pkg::HANDLE_W-1:0] i_granted_handle,
    input logic [ffca_pkg::GSZ_W-1:0]    i_granted_size,
    input logic                          i_reused
);

    `FFCA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_granted_handle) && $stable(i_granted_size) && $stable(i_reused), "stalled result word changed")
    `FFCA_ASSERT_IMP(a_err_clean, i_clk, i_rst_n, i_out_valid && i_status != ffca_pkg::ST_OK, i_granted_handle == '0 && i_granted_size == '0 && !i_reused, "error result carries data")
    `FFCA_ASSERT_IMP(a_reuse_ok, i_clk, i_rst_n, i_out_valid && i_reused, i_status == ffca_pkg::ST_OK, "reuse flagged on failed request")
    `FFCA_ASSERT_IMP(a_ok_size, i_clk, i_rst_n, i_out_valid && i_status == ffca_pkg::ST_OK, i_granted_size != '0 && (i_granted_size & ffca_pkg::GSZ_W'(ffca_pkg::WORD_BYTES - 1)) == '0, "granted size not a whole nonzero word count")

endmodule

bind first_fit_chunk_allocator ffca_checker u_ffca_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_status         (o_rsp.status),
    .i_granted_handle (o_rsp.granted_handle),
    .i_granted_size   (o_rsp.granted_size),
    .i_reused         (o_rsp.reused)
);
